>>> rtl/teq_pkg.sv
// Shared types and constants of the timed event queue.
// Field widths, action and status codes, cell control group.
// No dependencies.
`default_nettype none

package teq_pkg;

   localparam int TimeW   = 32;
   localparam int IdentW  = 16;
   localparam int ActW    = 3;
   localparam int StatusW = 3;
   localparam int CountW  = 5;

   localparam int DepthDef  = 16;
   localparam int IdBitsDef = 16;

   localparam logic [ActW-1:0] ACT_ADD      = 3'd0;
   localparam logic [ActW-1:0] ACT_ADD_FUT  = 3'd1;
   localparam logic [ActW-1:0] ACT_REMOVE   = 3'd2;
   localparam logic [ActW-1:0] ACT_ADVANCE  = 3'd3;
   localparam logic [ActW-1:0] ACT_LIST_ALL = 3'd4;
   localparam logic [ActW-1:0] ACT_LIST_AT  = 3'd5;

   localparam logic [StatusW-1:0] ST_ACCEPTED = 3'd0;
   localparam logic [StatusW-1:0] ST_FULL     = 3'd1;
   localparam logic [StatusW-1:0] ST_NOT_FUT  = 3'd2;
   localparam logic [StatusW-1:0] ST_FIRED    = 3'd3;
   localparam logic [StatusW-1:0] ST_LISTED   = 3'd4;
   localparam logic [StatusW-1:0] ST_NONE     = 3'd5;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } teq_cell_op_type;

   typedef struct packed {
      teq_cell_op_type   op;
      logic [TimeW-1:0]  ins_due;
   } teq_cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/teq_cell.sv
// One slot of the sorted event row: valid bit, due time and identifier.
// Inserts in order against left neighbor; shifts from right or head.
// Depends on teq_pkg.
`default_nettype none

module teq_cell import teq_pkg::*; #(
   parameter int ID_W = IdentW
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire teq_cell_ctl_type ctl,
   input  wire logic [ID_W-1:0]  ins_ident,
   input  wire logic             left_vld,
   input  wire logic [TimeW-1:0] left_due,
   input  wire logic [ID_W-1:0]  left_ident,
   input  wire logic             right_vld,
   input  wire logic [TimeW-1:0] right_due,
   input  wire logic [ID_W-1:0]  right_ident,
   input  wire logic [TimeW-1:0] head_due,
   input  wire logic [ID_W-1:0]  head_ident,
   input  wire logic             append,
   output logic                  vld,
   output logic [TimeW-1:0]      due,
   output logic [ID_W-1:0]       ident
);

   logic             vld_ff, vld_in;
   logic [TimeW-1:0] due_ff, due_in;
   logic [ID_W-1:0]  ident_ff, ident_in;
   logic             left_gt, own_gt;

   assign left_gt = left_vld && (left_due > ctl.ins_due);
   assign own_gt  = !vld_ff || (due_ff > ctl.ins_due);

   always_comb begin
      vld_in   = vld_ff;
      due_in   = due_ff;
      ident_in = ident_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (left_gt) begin
               vld_in   = 1'b1;
               due_in   = left_due;
               ident_in = left_ident;
            end else if (left_vld && own_gt) begin
               vld_in   = 1'b1;
               due_in   = ctl.ins_due;
               ident_in = ins_ident;
            end
         end
         CELL_SHIFT: begin
            if (append) begin
               vld_in   = 1'b1;
               due_in   = head_due;
               ident_in = head_ident;
            end else begin
               vld_in   = right_vld;
               due_in   = right_due;
               ident_in = right_ident;
            end
         end
         default: begin
            vld_in = vld_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      due_ff   <= due_in;
      ident_ff <= ident_in;
   end

   assign vld   = vld_ff;
   assign due   = due_ff;
   assign ident = ident_ff;

endmodule

`default_nettype wire

>>> rtl/timed_event_queue_core.sv
// Top level of the timed event queue: cell row, sequencer, result register.
// Depends on teq_pkg and teq_cell.
//
// Events sit in a row of DEPTH cells, sorted by due time with equal times in
// insertion order; cell 0 holds the earliest. An add, an add-if-future or an
// unused action code is answered from idle; an add that goes in has all cells
// compare against the new time in parallel and the tail past the insert point
// move right by one. Remove, advance and the two list actions rotate the row
// through cell 0, one entry a cycle unless a held-off result port blocks a
// pending result: the head either leaves the row or is appended behind the
// kept entries, and the final result follows the scan. A new item is
// accepted only while the result register is empty or its result is taken
// in the same cycle, so the final result of one item is loaded and then taken
// before the next item goes in. The table needs no clearing after reset.
`default_nettype none

module timed_event_queue_core import teq_pkg::*; #(
   parameter int DEPTH   = DepthDef,
   parameter int ID_BITS = IdBitsDef
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [ActW-1:0]    req_action,
   input  wire logic [TimeW-1:0]   req_time_arg,
   input  wire logic [IdentW-1:0]  req_event_id,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [StatusW-1:0]      rsp_status,
   output logic [TimeW-1:0]        rsp_due_time,
   output logic [IdentW-1:0]       rsp_ident,
   output logic [CountW-1:0]       rsp_removed_count,
   output logic                    rsp_last
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam int IdxW = $clog2(DEPTH);
   localparam int IdW  = (ID_BITS < IdentW) ? ID_BITS : IdentW;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CntW-1:0]  occ_ff, occ_in;
   logic [TimeW-1:0] now_ff, now_in;
   logic [CntW-1:0]  rem_ff, rem_in;
   logic [CntW-1:0]  drop_cnt_ff, drop_cnt_in;
   logic [TimeW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic             match_en_ff, match_en_in;
   logic             emit_mode_ff, emit_mode_in;
   logic             drop_mode_ff, drop_mode_in;
   logic             count_mode_ff, count_mode_in;
   logic [StatusW-1:0] emit_status_ff, emit_status_in;

   logic               pend_valid_ff, pend_valid_in;
   logic [StatusW-1:0] pend_status_ff, pend_status_in;
   logic [TimeW-1:0]   pend_due_ff, pend_due_in;
   logic [IdW-1:0]     pend_ident_ff, pend_ident_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [StatusW-1:0] rsp_status_ff, rsp_status_in;
   logic [TimeW-1:0]   rsp_due_ff, rsp_due_in;
   logic [IdW-1:0]     rsp_ident_ff, rsp_ident_in;
   logic [CntW-1:0]    rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_load;

   logic               out_free, accept, full, future, do_insert;
   logic [TimeW-1:0]   adv_sum;
   logic               head_match, head_emit, head_drop, scan_step;
   logic [IdxW-1:0]    app_idx;
   logic [IdW-1:0]     new_ident;
   teq_cell_ctl_type   cell_ctl;

   logic               cell_vld [DEPTH];
   logic [TimeW-1:0]   cell_due [DEPTH];
   logic [IdW-1:0]     cell_id  [DEPTH];
   logic [DEPTH-1:0]   vld_vec, occ_mask, append_vec;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (occ_ff == CntW'(DEPTH));
   assign future    = req_time_arg > now_ff;
   assign adv_sum   = now_ff + req_time_arg;
   assign new_ident = req_event_id[IdW-1:0];
   assign do_insert = accept && !full &&
                      ((req_action == ACT_ADD) || ((req_action == ACT_ADD_FUT) && future));

   assign head_match = match_en_ff && (cell_due[0] >= lo_ff) && (cell_due[0] <= hi_ff);
   assign head_emit  = emit_mode_ff && head_match;
   assign head_drop  = drop_mode_ff && head_match;
   assign scan_step  = (state_ff == S_SCAN) && (rem_ff != '0) &&
                       !(head_emit && pend_valid_ff && !out_free);
   assign app_idx    = IdxW'(occ_ff - 1'b1);

   always_comb begin
      cell_ctl.ins_due = req_time_arg;
      if (do_insert) begin
         cell_ctl.op = CELL_INSERT;
      end else if (scan_step) begin
         cell_ctl.op = CELL_SHIFT;
      end else begin
         cell_ctl.op = CELL_HOLD;
      end
      for (int i = 0; i < DEPTH; i++) begin
         append_vec[i] = scan_step && !head_drop && (app_idx == IdxW'(i));
         vld_vec[i]    = cell_vld[i];
         occ_mask[i]   = (CntW'(i) < occ_ff);
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic             l_vld, r_vld;
      logic [TimeW-1:0] l_due, r_due;
      logic [IdW-1:0]   l_id, r_id;

      if (g == 0) begin : g_first
         assign l_vld = 1'b1;
         assign l_due = '0;
         assign l_id  = '0;
      end else begin : g_mid
         assign l_vld = cell_vld[g-1];
         assign l_due = cell_due[g-1];
         assign l_id  = cell_id[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign r_vld = 1'b0;
         assign r_due = '0;
         assign r_id  = '0;
      end else begin : g_inner
         assign r_vld = cell_vld[g+1];
         assign r_due = cell_due[g+1];
         assign r_id  = cell_id[g+1];
      end

      teq_cell #(
         .ID_W(IdW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .ins_ident   (new_ident),
         .left_vld    (l_vld),
         .left_due    (l_due),
         .left_ident  (l_id),
         .right_vld   (r_vld),
         .right_due   (r_due),
         .right_ident (r_id),
         .head_due    (cell_due[0]),
         .head_ident  (cell_id[0]),
         .append      (append_vec[g]),
         .vld         (cell_vld[g]),
         .due         (cell_due[g]),
         .ident       (cell_id[g])
      );
   end

   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      now_in         = now_ff;
      rem_in         = rem_ff;
      drop_cnt_in    = drop_cnt_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      match_en_in    = match_en_ff;
      emit_mode_in   = emit_mode_ff;
      drop_mode_in   = drop_mode_ff;
      count_mode_in  = count_mode_ff;
      emit_status_in = emit_status_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_due_in    = pend_due_ff;
      pend_ident_in  = pend_ident_ff;
      out_load       = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_due_in     = rsp_due_ff;
      rsp_ident_in   = rsp_ident_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_due_in    = '0;
               rsp_ident_in  = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               rem_in        = occ_ff;
               drop_cnt_in   = '0;
               pend_valid_in = 1'b0;
               lo_in         = req_time_arg;
               hi_in         = req_time_arg;
               match_en_in   = 1'b1;
               emit_mode_in  = 1'b0;
               drop_mode_in  = 1'b0;
               count_mode_in = 1'b0;
               emit_status_in = ST_LISTED;
               unique case (req_action) inside
                  ACT_ADD, ACT_ADD_FUT: begin
                     out_load = 1'b1;
                     if ((req_action == ACT_ADD_FUT) && !future) begin
                        rsp_status_in = ST_NOT_FUT;
                     end else if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_ACCEPTED;
                        occ_in        = occ_ff + 1'b1;
                     end
                  end
                  ACT_REMOVE: begin
                     drop_mode_in  = 1'b1;
                     count_mode_in = 1'b1;
                     state_in      = S_SCAN;
                  end
                  ACT_ADVANCE: begin
                     now_in         = adv_sum;
                     lo_in          = now_ff;
                     hi_in          = adv_sum;
                     match_en_in    = adv_sum >= now_ff;
                     emit_mode_in   = 1'b1;
                     drop_mode_in   = 1'b1;
                     emit_status_in = ST_FIRED;
                     state_in       = S_SCAN;
                  end
                  ACT_LIST_ALL: begin
                     lo_in        = '0;
                     hi_in        = '1;
                     emit_mode_in = 1'b1;
                     state_in     = S_SCAN;
                  end
                  ACT_LIST_AT: begin
                     emit_mode_in = 1'b1;
                     state_in     = S_SCAN;
                  end
                  default: begin
                     out_load      = 1'b1;
                     rsp_status_in = ST_NONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rem_ff == '0) begin
               state_in = S_FINISH;
            end else if (scan_step) begin
               rem_in = rem_ff - 1'b1;
               if (head_drop) begin
                  occ_in      = occ_ff - 1'b1;
                  drop_cnt_in = drop_cnt_ff + 1'b1;
               end
               if (head_emit) begin
                  if (pend_valid_ff) begin
                     out_load      = 1'b1;
                     rsp_status_in = pend_status_ff;
                     rsp_due_in    = pend_due_ff;
                     rsp_ident_in  = pend_ident_ff;
                     rsp_count_in  = '0;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_status_in = emit_status_ff;
                  pend_due_in    = cell_due[0];
                  pend_ident_in  = cell_id[0];
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
               if (pend_valid_ff) begin
                  rsp_status_in = pend_status_ff;
                  rsp_due_in    = pend_due_ff;
                  rsp_ident_in  = pend_ident_ff;
                  rsp_count_in  = '0;
               end else begin
                  rsp_due_in   = '0;
                  rsp_ident_in = '0;
                  if (count_mode_ff && (drop_cnt_ff != '0)) begin
                     rsp_status_in = ST_ACCEPTED;
                     rsp_count_in  = drop_cnt_ff;
                  end else begin
                     rsp_status_in = ST_NONE;
                     rsp_count_in  = '0;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         now_ff        <= '0;
         rem_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         now_ff        <= now_in;
         rem_ff        <= rem_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      drop_cnt_ff    <= drop_cnt_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      match_en_ff    <= match_en_in;
      emit_mode_ff   <= emit_mode_in;
      drop_mode_ff   <= drop_mode_in;
      count_mode_ff  <= count_mode_in;
      emit_status_ff <= emit_status_in;
      pend_status_ff <= pend_status_in;
      pend_due_ff    <= pend_due_in;
      pend_ident_ff  <= pend_ident_in;
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_due_ff    <= rsp_due_in;
         rsp_ident_ff  <= rsp_ident_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_due_time      = rsp_due_ff;
   assign rsp_ident         = IdentW'(rsp_ident_ff);
   assign rsp_removed_count = CountW'(rsp_count_ff);
   assign rsp_last          = rsp_last_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CntW'(DEPTH))
      else $error("occupancy beyond table depth");

   a_vld_packed: assert property (@(posedge clock) disable iff (reset)
      vld_vec == occ_mask)
      else $error("cell valid bits disagree with occupancy");

   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (occ_ff >= rem_ff))
      else $error("unscanned entries exceed row length");

   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending result left over in idle");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || (state_ff != S_IDLE)))
      else $error("accepted item produced neither result nor scan");

endmodule

`default_nettype wire
